FILE: rtl/mwcg_pkg.sv
`default_nettype none
package mwcg_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_X   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Y   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIAMETER   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEPS_REV  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_SCL  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_BAND  = 3'd5;

   localparam logic [1:0] WHEEL_FL = 2'd0;
   localparam logic [1:0] WHEEL_FR = 2'd1;
   localparam logic [1:0] WHEEL_BL = 2'd2;
   localparam logic [1:0] WHEEL_BR = 2'd3;

   // Pi in Q24.
   localparam logic [25:0] PI_Q24 = 26'd52707179;

   localparam int SQRT_STAGES = 33;
   localparam int QUOT_BITS   = 16;

   typedef struct packed {
      logic [9:0]  offset_x;
      logic [9:0]  offset_y;
      logic [9:0]  diameter;
      logic [15:0] steps_rev;
      logic [11:0] speed_scale;
      logic [15:0] zero_band;
   } mwcg_cfg_type;

   // Per wheel context that travels with the displacement.
   typedef struct packed {
      logic [1:0]  wheel;
      logic        dx_neg;
      logic        dy_neg;
      logic        in_band;
      logic [31:0] ax;
      logic [31:0] ay;
   } mwcg_ctx_type;

endpackage
`default_nettype wire

FILE: rtl/mwcg_req_if.sv
`default_nettype none
interface mwcg_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] move_x;
   logic signed [15:0] move_y;
   logic signed [19:0] move_turn;

   modport source(output valid, move_x, move_y, move_turn, input ready);
   modport sink(input valid, move_x, move_y, move_turn, output ready);
endinterface
`default_nettype wire

FILE: rtl/mwcg_rsp_if.sv
`default_nettype none
interface mwcg_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  wheel_index;
   logic [15:0] step_count;
   logic [16:0] speed_magnitude;
   logic        direction;
   logic        last_wheel;

   modport source(output valid, wheel_index, step_count, speed_magnitude, direction,
                  last_wheel, input ready);
   modport sink(input valid, wheel_index, step_count, speed_magnitude, direction,
                last_wheel, output ready);
endinterface
`default_nettype wire

FILE: rtl/mwcg_front.sv
`default_nettype none
module mwcg_front
   import mwcg_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         adv,
   input  wire mwcg_cfg_type cfg,
   mwcg_req_if.sink          req_chan,
   output logic              out_valid,
   output mwcg_ctx_type      out_ctx,
   output logic [65:0]       out_rad
);

   logic               busy_ff;
   logic [1:0]         cnt_ff;
   logic signed [15:0] x_ff, y_ff;
   logic signed [19:0] t_ff;

   logic               v1_ff, v2_ff, v3_ff;
   logic [1:0]         w1_ff;
   logic [33:0]        dx_ff, dy_ff;
   logic [33:0]        dx_in, dy_in;
   mwcg_ctx_type       ctx2_ff, ctx3_ff, ctx2_in;
   logic [63:0]        sx_ff, sy_ff;
   logic [65:0]        rad_ff;

   logic signed [10:0] wx, wy;
   logic signed [30:0] twx, twy;
   logic [33:0]        ndx, ndy;
   logic               accept;

   assign req_chan.ready = !busy_ff || (adv && cnt_ff == WHEEL_BR);
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= WHEEL_FL;
      end else if (accept) begin
         busy_ff <= 1'b1;
         cnt_ff  <= WHEEL_FL;
      end else if (adv && busy_ff) begin
         cnt_ff <= cnt_ff + 2'd1;
         if (cnt_ff == WHEEL_BR) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff <= req_chan.move_x;
         y_ff <= req_chan.move_y;
         t_ff <= req_chan.move_turn;
      end
   end

   // Left wheels sit at negative x, front wheels at positive y.
   always_comb begin
      wx    = cnt_ff[0] ? $signed({1'b0, cfg.offset_x}) : -$signed({1'b0, cfg.offset_x});
      wy    = cnt_ff[1] ? -$signed({1'b0, cfg.offset_y}) : $signed({1'b0, cfg.offset_y});
      twx   = t_ff * wx;
      twy   = t_ff * wy;
      dx_in = {{2{x_ff[15]}}, x_ff, 16'b0} - {{3{twy[30]}}, twy};
      dy_in = {{2{y_ff[15]}}, y_ff, 16'b0} + {{3{twx[30]}}, twx};
   end

   always_comb begin
      ndx             = -dx_ff;
      ndy             = -dy_ff;
      ctx2_in.wheel   = w1_ff;
      ctx2_in.dx_neg  = dx_ff[33];
      ctx2_in.dy_neg  = dy_ff[33];
      ctx2_in.ax      = dx_ff[33] ? ndx[31:0] : dx_ff[31:0];
      ctx2_in.ay      = dy_ff[33] ? ndy[31:0] : dy_ff[31:0];
      ctx2_in.in_band = (ctx2_in.ax < {cfg.zero_band, 16'b0}) &&
                        (ctx2_in.ay < {cfg.zero_band, 16'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= busy_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w1_ff   <= cnt_ff;
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         ctx2_ff <= ctx2_in;
         sx_ff   <= ctx2_in.ax * ctx2_in.ax;
         sy_ff   <= ctx2_in.ay * ctx2_in.ay;
         ctx3_ff <= ctx2_ff;
         rad_ff  <= {2'b0, sx_ff} + {2'b0, sy_ff};
      end
   end

   assign out_valid = v3_ff;
   assign out_ctx   = ctx3_ff;
   assign out_rad   = rad_ff;

endmodule
`default_nettype wire

FILE: rtl/mwcg_sqrt.sv
`default_nettype none
module mwcg_sqrt
   import mwcg_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         adv,
   input  wire logic         in_valid,
   input  wire mwcg_ctx_type in_ctx,
   input  wire logic [65:0]  in_rad,
   output logic              out_valid,
   output mwcg_ctx_type      out_ctx,
   output logic [32:0]       out_len
);

   typedef struct packed {
      mwcg_ctx_type ctx;
      logic [65:0]  rad;
      logic [36:0]  rem;
      logic [32:0]  root;
   } sq_type;

   sq_type st_ff [1:SQRT_STAGES];
   logic   vld_ff [1:SQRT_STAGES];

   // One result bit per stage: two radicand bits come down each time.
   for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_step
      sq_type      cur, st_in;
      logic        cur_v;
      logic [36:0] rem2, trial;

      if (j == 0) begin : g_first
         assign cur   = '{ctx: in_ctx, rad: in_rad, rem: '0, root: '0};
         assign cur_v = in_valid;
      end else begin : g_rest
         assign cur   = st_ff[j];
         assign cur_v = vld_ff[j];
      end

      always_comb begin
         rem2      = {cur.rem[34:0], cur.rad[65:64]};
         trial     = {2'b0, cur.root, 2'b01};
         st_in     = cur;
         st_in.rad = {cur.rad[63:0], 2'b0};
         if (rem2 >= trial) begin
            st_in.rem  = rem2 - trial;
            st_in.root = {cur.root[31:0], 1'b1};
         end else begin
            st_in.rem  = rem2;
            st_in.root = {cur.root[31:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[j+1] <= cur_v;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[j+1] <= st_in;
         end
      end
   end

   assign out_valid = vld_ff[SQRT_STAGES];
   assign out_ctx   = st_ff[SQRT_STAGES].ctx;
   assign out_len   = st_ff[SQRT_STAGES].root;

endmodule
`default_nettype wire

FILE: rtl/mwcg_div.sv
`default_nettype none
module mwcg_div
   import mwcg_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         adv,
   input  wire mwcg_cfg_type cfg,
   input  wire logic         in_valid,
   input  wire mwcg_ctx_type in_ctx,
   input  wire logic [32:0]  in_len,
   output logic              out_valid,
   output logic [1:0]        out_wheel,
   output logic [15:0]       out_steps,
   output logic signed [16:0] out_ux,
   output logic signed [16:0] out_uy
);

   typedef struct packed {
      logic [1:0]  wheel;
      logic        dx_neg;
      logic        dy_neg;
      logic        zero;
      logic [32:0] len;
      logic [56:0] rs;
      logic [35:0] ds;
      logic        sat;
      logic [15:0] qs;
      logic [46:0] rx;
      logic [46:0] ry;
      logic [15:0] qx;
      logic [15:0] qy;
   } dv_type;

   dv_type d0_in, d0_ff, d1_in, d1_ff;
   logic   v0_ff, v1_ff;
   dv_type st_ff [1:QUOT_BITS];
   logic   vld_ff [1:QUOT_BITS];
   logic [48:0] len_spr;

   // Step count numerator is len*steps*256, denominator diameter*pi.
   always_comb begin
      len_spr       = in_len * cfg.steps_rev;
      d0_in.wheel   = in_ctx.wheel;
      d0_in.dx_neg  = in_ctx.dx_neg;
      d0_in.dy_neg  = in_ctx.dy_neg;
      d0_in.zero    = in_ctx.in_band || (in_len == 33'd0);
      d0_in.len     = in_len;
      d0_in.rs      = {len_spr, 8'b0};
      d0_in.ds      = cfg.diameter * PI_Q24;
      d0_in.sat     = 1'b0;
      d0_in.qs      = '0;
      d0_in.rx      = {in_ctx.ax, 15'b0};
      d0_in.ry      = {in_ctx.ay, 15'b0};
      d0_in.qx      = '0;
      d0_in.qy      = '0;
   end

   // A quotient past 16 bits saturates; a zero diameter lands here too.
   always_comb begin
      d1_in     = d0_ff;
      d1_in.sat = d0_ff.rs >= {5'b0, d0_ff.ds, 16'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d0_ff <= d0_in;
         d1_ff <= d1_in;
      end
   end

   for (genvar j = 0; j < QUOT_BITS; j++) begin : g_bit
      localparam int B = QUOT_BITS - 1 - j;
      dv_type      cur, st_in;
      logic        cur_v;
      logic [56:0] dsh;
      logic [47:0] lsh;

      if (j == 0) begin : g_first
         assign cur   = d1_ff;
         assign cur_v = v1_ff;
      end else begin : g_rest
         assign cur   = st_ff[j];
         assign cur_v = vld_ff[j];
      end

      always_comb begin
         dsh   = 57'(cur.ds) << B;
         lsh   = 48'(cur.len) << B;
         st_in = cur;
         if (cur.rs >= dsh) begin
            st_in.rs    = cur.rs - dsh;
            st_in.qs[B] = 1'b1;
         end
         if ({1'b0, cur.rx} >= lsh) begin
            st_in.rx    = 47'({1'b0, cur.rx} - lsh);
            st_in.qx[B] = 1'b1;
         end
         if ({1'b0, cur.ry} >= lsh) begin
            st_in.ry    = 47'({1'b0, cur.ry} - lsh);
            st_in.qy[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[j+1] <= cur_v;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[j+1] <= st_in;
         end
      end
   end

   dv_type fin;
   logic signed [16:0] mx, my;
   assign fin       = st_ff[QUOT_BITS];
   assign mx        = $signed({1'b0, fin.qx});
   assign my        = $signed({1'b0, fin.qy});
   assign out_valid = vld_ff[QUOT_BITS];
   assign out_wheel = fin.wheel;
   assign out_steps = fin.sat ? 16'hFFFF : fin.qs;
   assign out_ux    = fin.zero ? 17'sd0 : (fin.dx_neg ? -mx : mx);
   assign out_uy    = fin.zero ? 17'sd0 : (fin.dy_neg ? -my : my);

endmodule
`default_nettype wire

FILE: rtl/mecanum_wheel_command_generator.sv
`default_nettype none
// Channel  | Direction | Handshake     | Payload
// req_chan | in        | valid/ready   | move_x, move_y, move_turn (one move command)
// rsp_chan | out       | valid/ready   | wheel_index, step_count, speed_magnitude,
//          |           |               | direction, last_wheel (four per command)
// csr      | in        | csr_write_en  | csr_index, csr_write_data
//
// Each request issues four wheel jobs, one per cycle while rsp_chan does not stall; a
// new request can be taken as the last job of the one before issues, and the wheel job
// issue slot is the limit. A wheel result passes 3 displacement, 33 square root, 18
// divide and 3 mixing and output stages. Reset is synchronous, clears the valid bits and
// sets the config registers to defaults. A stall on rsp_chan freezes every stage at once.
module mecanum_wheel_command_generator
   import mwcg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   mwcg_req_if.sink                    req_chan,
   mwcg_rsp_if.source                  rsp_chan,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   mwcg_cfg_type cfg_ff;
   logic         adv;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_x    <= 10'd100;
         cfg_ff.offset_y    <= 10'd52;
         cfg_ff.diameter    <= 10'd80;
         cfg_ff.steps_rev   <= 16'd200;
         cfg_ff.speed_scale <= 12'd500;
         cfg_ff.zero_band   <= 16'd100;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_OFFSET_X:  cfg_ff.offset_x    <= csr_write_data[9:0];
            CSR_OFFSET_Y:  cfg_ff.offset_y    <= csr_write_data[9:0];
            CSR_DIAMETER:  cfg_ff.diameter    <= csr_write_data[9:0];
            CSR_STEPS_REV: cfg_ff.steps_rev   <= csr_write_data;
            CSR_SPEED_SCL: cfg_ff.speed_scale <= csr_write_data[11:0];
            CSR_ZERO_BAND: cfg_ff.zero_band   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // The whole pipeline moves when the output register is empty or being drained.
   logic rsp_valid_ff;
   assign adv = !rsp_valid_ff || rsp_chan.ready;

   logic         f_valid;
   mwcg_ctx_type f_ctx;
   logic [65:0]  f_rad;

   mwcg_front u_front (
      .clock, .reset, .adv, .cfg(cfg_ff), .req_chan,
      .out_valid(f_valid), .out_ctx(f_ctx), .out_rad(f_rad)
   );

   logic         s_valid;
   mwcg_ctx_type s_ctx;
   logic [32:0]  s_len;

   mwcg_sqrt u_sqrt (
      .clock, .reset, .adv,
      .in_valid(f_valid), .in_ctx(f_ctx), .in_rad(f_rad),
      .out_valid(s_valid), .out_ctx(s_ctx), .out_len(s_len)
   );

   logic               d_valid;
   logic [1:0]         d_wheel;
   logic [15:0]        d_steps;
   logic signed [16:0] d_ux, d_uy;

   mwcg_div u_div (
      .clock, .reset, .adv, .cfg(cfg_ff),
      .in_valid(s_valid), .in_ctx(s_ctx), .in_len(s_len),
      .out_valid(d_valid), .out_wheel(d_wheel), .out_steps(d_steps),
      .out_ux(d_ux), .out_uy(d_uy)
   );

   // Front left and back right mix uy + ux; the other two mix uy - ux.
   logic               m_valid_ff, r_valid_ff;
   logic [1:0]         m_wheel_ff, r_wheel_ff;
   logic [15:0]        m_steps_ff, r_steps_ff;
   logic signed [17:0] mix_ff, mix_in;
   logic signed [30:0] raw_ff;

   always_comb begin
      if (d_wheel == WHEEL_FL || d_wheel == WHEEL_BR) begin
         mix_in = 18'(d_uy) + 18'(d_ux);
      end else begin
         mix_in = 18'(d_uy) - 18'(d_ux);
      end
   end

   // Output stage: magnitude in Q7 with saturation, and the motor direction, which
   // is inverted on the left wheels.
   logic [30:0] raw_mag;
   logic [22:0] spd_full;
   logic        raw_neg;
   logic [1:0]  rsp_wheel_ff;
   logic [15:0] rsp_steps_ff;
   logic [16:0] rsp_speed_ff;
   logic        rsp_dir_ff;

   assign raw_neg  = raw_ff[30];
   assign raw_mag  = raw_neg ? 31'(-raw_ff) : 31'(raw_ff);
   assign spd_full = raw_mag[30:8];

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         r_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff   <= d_valid;
         r_valid_ff   <= m_valid_ff;
         rsp_valid_ff <= r_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_wheel_ff   <= d_wheel;
         m_steps_ff   <= d_steps;
         mix_ff       <= mix_in;
         r_wheel_ff   <= m_wheel_ff;
         r_steps_ff   <= m_steps_ff;
         raw_ff       <= $signed({1'b0, cfg_ff.speed_scale}) * mix_ff;
         rsp_wheel_ff <= r_wheel_ff;
         rsp_steps_ff <= r_steps_ff;
         rsp_speed_ff <= (spd_full > 23'd131071) ? 17'h1FFFF : spd_full[16:0];
         rsp_dir_ff   <= r_wheel_ff[0] ? !raw_neg : raw_neg;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.wheel_index     = rsp_wheel_ff;
   assign rsp_chan.step_count      = rsp_steps_ff;
   assign rsp_chan.speed_magnitude = rsp_speed_ff;
   assign rsp_chan.direction       = rsp_dir_ff;
   assign rsp_chan.last_wheel      = (rsp_wheel_ff == WHEEL_BR);

   // Expected wheel of the next delivered result; results must come out in wheel order.
   logic [1:0] exp_wheel_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_wheel_ff <= WHEEL_FL;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         exp_wheel_ff <= exp_wheel_ff + 2'd1;
      end
   end

   a_wheel_order: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.wheel_index == exp_wheel_ff)
      else $error("wheel results out of order");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.last_wheel == (rsp_chan.wheel_index == WHEEL_BR))
      else $error("last flag not on back right wheel");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");

endmodule
`default_nettype wire

FILE: test/tb_mecanum_wheel_command_generator.sv
`timescale 1ns / 1ps
module tb_mecanum_wheel_command_generator;
   import mwcg_pkg::*;

   typedef struct {
      logic signed [15:0] move_x;
      logic signed [15:0] move_y;
      logic signed [19:0] move_turn;
   } move_cmd_type;

   typedef struct {
      logic [1:0]  wheel_index;
      logic [15:0] step_count;
      logic [16:0] speed_magnitude;
      logic        direction;
      logic        last_wheel;
   } wheel_cmd_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   mwcg_req_if req_chan();
   mwcg_rsp_if rsp_chan();

   // Shadow copy of the block's registers, updated whenever a register is written.
   mwcg_cfg_type geometry;

   // Move requests still to be sent, and wheel commands still to arrive.
   move_cmd_type  move_backlog[$];
   wheel_cmd_type wheel_due[$];

   int  mismatches;
   int  send_gap;
   int  stall_gap;
   // Once set, neither side inserts idle cycles any more.
   bit  steady;

   mecanum_wheel_command_generator u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan.sink),
      .rsp_chan       (rsp_chan.source),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Integer square root, floor of sqrt(v), one result bit per pass.
   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Works out the four wheel commands of one move request and queues them in
   // wheel order. Wheels sit at (-ox,+oy), (+ox,+oy), (-ox,-oy), (+ox,-oy), and
   // each one moves by (x - turn*wy, y + turn*wx) in Q16 millimeters.
   function automatic void expect_wheels(move_cmd_type m);
      longint          x, y, t, wx, wy, dx, dy, ux, uy, mix, raw;
      longint unsigned ax, ay, len, band, steps, spd;
      bit              left;
      wheel_cmd_type   w;
      x = m.move_x;
      y = m.move_y;
      t = m.move_turn;
      band = longint'(geometry.zero_band) << 16;
      for (int k = 0; k < 4; k++) begin
         left = (k == WHEEL_FL) || (k == WHEEL_BL);
         wx = left ? -longint'(geometry.offset_x) : longint'(geometry.offset_x);
         wy = (k == WHEEL_FL || k == WHEEL_FR) ? longint'(geometry.offset_y)
                                                : -longint'(geometry.offset_y);
         dx = x * 65536 - t * wy;
         dy = y * 65536 + t * wx;
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         len = root_floor(ax * ax + ay * ay);
         // A zero diameter would divide by zero; the block pins the count instead.
         if (geometry.diameter == 0) begin
            steps = 65535;
         end else begin
            steps = (len * geometry.steps_rev * 256) /
                    (longint'(geometry.diameter) * longint'(PI_Q24));
            if (steps > 65535) steps = 65535;
         end
         // Inside the dead band, or with no displacement at all, there is no direction.
         ux = 0;
         uy = 0;
         if (!(ax < band && ay < band) && len != 0) begin
            ux = (dx * 32768) / longint'(len);
            uy = (dy * 32768) / longint'(len);
         end
         mix = (k == WHEEL_FL || k == WHEEL_BR) ? uy + ux : uy - ux;
         raw = longint'(geometry.speed_scale) * mix;
         spd = ((raw < 0) ? -raw : raw) >> 8;
         if (spd > 131071) spd = 131071;
         w.wheel_index     = k[1:0];
         w.step_count      = steps[15:0];
         w.speed_magnitude = spd[16:0];
         // Left motors are mounted mirrored, so their direction bit is inverted.
         w.direction       = left ? (raw < 0) : (raw >= 0);
         w.last_wheel      = (k == WHEEL_BR);
         wheel_due.push_back(w);
      end
   endfunction

   // Request driver: takes move requests from the backlog and predicts on acceptance.
   always @(posedge clock) begin
      move_cmd_type m;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            m.move_x    = req_chan.move_x;
            m.move_y    = req_chan.move_y;
            m.move_turn = req_chan.move_turn;
            expect_wheels(m);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (move_backlog.size() > 0) begin
               m = move_backlog.pop_front();
               req_chan.valid     <= 1'b1;
               req_chan.move_x    <= m.move_x;
               req_chan.move_y    <= m.move_y;
               req_chan.move_turn <= m.move_turn;
               if (!steady && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 3);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each wheel command against the oldest prediction and
   // throttles ready in short random bursts.
   always @(posedge clock) begin
      wheel_cmd_type w;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_gap = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (wheel_due.size() == 0) begin
               $display("%0t: wheel command expected none actual wheel=%0d steps=%0d",
                        $time, rsp_chan.wheel_index, rsp_chan.step_count);
               mismatches++;
            end else begin
               w = wheel_due.pop_front();
               if (rsp_chan.wheel_index !== w.wheel_index) begin
                  $display("%0t: wheel_index expected %0d actual %0d", $time,
                           w.wheel_index, rsp_chan.wheel_index);
                  mismatches++;
               end
               if (rsp_chan.step_count !== w.step_count) begin
                  $display("%0t: step_count expected %0d actual %0d", $time,
                           w.step_count, rsp_chan.step_count);
                  mismatches++;
               end
               if (rsp_chan.speed_magnitude !== w.speed_magnitude) begin
                  $display("%0t: speed_magnitude expected %0d actual %0d", $time,
                           w.speed_magnitude, rsp_chan.speed_magnitude);
                  mismatches++;
               end
               if (rsp_chan.direction !== w.direction) begin
                  $display("%0t: direction expected %0d actual %0d", $time,
                           w.direction, rsp_chan.direction);
                  mismatches++;
               end
               if (rsp_chan.last_wheel !== w.last_wheel) begin
                  $display("%0t: last_wheel expected %0d actual %0d", $time,
                           w.last_wheel, rsp_chan.last_wheel);
                  mismatches++;
               end
            end
         end
         if (stall_gap > 0) begin
            stall_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!steady && $urandom_range(0, 4) == 0) stall_gap = $urandom_range(1, 3);
         end
      end
   end

   // Register writes happen only while the block is idle.
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= val;
      case (idx)
         CSR_OFFSET_X:  geometry.offset_x    = val[9:0];
         CSR_OFFSET_Y:  geometry.offset_y    = val[9:0];
         CSR_DIAMETER:  geometry.diameter    = val[9:0];
         CSR_STEPS_REV: geometry.steps_rev   = val;
         CSR_SPEED_SCL: geometry.speed_scale = val[11:0];
         CSR_ZERO_BAND: geometry.zero_band   = val;
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic write_geometry(int ox, int oy, int diam, int spr, int scl, int band);
      write_reg(CSR_OFFSET_X, 16'(ox));
      write_reg(CSR_OFFSET_Y, 16'(oy));
      write_reg(CSR_DIAMETER, 16'(diam));
      write_reg(CSR_STEPS_REV, 16'(spr));
      write_reg(CSR_SPEED_SCL, 16'(scl));
      write_reg(CSR_ZERO_BAND, 16'(band));
   endtask

   task automatic add_move(int x, int y, int t);
      move_cmd_type m;
      m.move_x    = 16'(x);
      m.move_y    = 16'(y);
      m.move_turn = 20'(t);
      move_backlog.push_back(m);
   endtask

   // Random moves: some land inside a typical dead band, some are modest, and the
   // rest span the whole field range so every input bit toggles.
   task automatic add_random_moves(int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: add_move($urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100,
                        $urandom_range(0, 64) - 32);
            1: add_move($urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                        $urandom_range(0, 131072) - 65536);
            default: add_move($urandom, $urandom, $urandom);
         endcase
      end
   endtask

   // Waits until every request has been taken and every wheel command has come back.
   task automatic drain();
      while (move_backlog.size() > 0 || req_chan.valid || wheel_due.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.move_x    = '0;
      req_chan.move_y    = '0;
      req_chan.move_turn = '0;
      rsp_chan.ready     = 1'b0;
      csr_write_en       = 1'b0;
      csr_index          = '0;
      csr_write_data     = '0;
      mismatches         = 0;
      steady             = 1'b0;
      geometry.offset_x    = 10'd100;
      geometry.offset_y    = 10'd52;
      geometry.diameter    = 10'd80;
      geometry.steps_rev   = 16'd200;
      geometry.speed_scale = 12'd500;
      geometry.zero_band   = 16'd100;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: directed moves covering field extremes and the dead band.
      add_move(0, 0, 0);
      add_move(32767, 0, 0);
      add_move(-32768, 0, 0);
      add_move(0, 32767, 0);
      add_move(0, -32768, 0);
      add_move(0, 0, 524287);
      add_move(0, 0, -524288);
      add_move(32767, 32767, 524287);
      add_move(-32768, -32768, -524288);
      add_move(32767, -32768, 524287);
      add_move(-32768, 32767, -524288);
      add_move(99, -99, 0);
      add_move(100, 0, 0);
      add_move(-100, 99, 0);
      add_move(50, 50, 1000);
      add_move(1000, 0, 0);
      add_move(0, 1000, 0);
      add_move(500, 500, 65536);
      add_move(-1, 1, -1);
      add_random_moves(10);
      drain();

      // Large geometry, no dead band: zero displacement and rate saturation.
      write_geometry(1023, 1023, 1, 65535, 4095, 0);
      add_move(0, 0, 0);
      add_move(1, 0, 0);
      add_move(0, -1, 0);
      add_move(32767, 0, 0);
      add_random_moves(10);
      drain();

      // Wheels on the center, huge wheel, slowest motor, no speed, wide dead band.
      write_geometry(0, 0, 1023, 1, 0, 65535);
      add_move(32767, -32768, 524287);
      add_random_moves(10);
      drain();

      // Zero diameter and zero steps per revolution.
      write_geometry(512, 341, 0, 0, 2048, 1);
      add_random_moves(8);
      drain();
      write_reg(CSR_DIAMETER, 16'd300);
      add_move(-32768, 32767, 524287);
      add_random_moves(8);
      drain();

      // Random geometries; the last one runs without any idle cycles.
      for (int p = 0; p < 3; p++) begin
         write_geometry($urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(1, 1023), $urandom_range(1, 65535),
                        $urandom_range(0, 4095), $urandom_range(0, 400));
         if (p == 2) steady = 1'b1;
         add_random_moves(13);
         drain();
      end

      repeat (300) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
